@@ rtl/chol_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chol_pkg
// Shared types, codes and command/status structs for the Cholesky block.
// ----------------------------------------------------------------------------
package chol_pkg;

  localparam int DATA_W = 32;
  localparam int ACC_W  = 64;
  localparam int IDX_W  = 3;
  localparam int ADDR_W = 6;

  typedef enum logic [4:0] {
    ST_LOAD,
    ST_ROW,
    ST_COL,
    ST_RD_D,
    ST_WT_D,
    ST_DOT_RD,
    ST_DOT_W1,
    ST_DOT_W2,
    ST_DOT_MUL,
    ST_DOT_ACC,
    ST_RD_A,
    ST_WT_A,
    ST_CHK,
    ST_DIV,
    ST_SQRT,
    ST_WR,
    ST_EMIT_RD,
    ST_EMIT_W,
    ST_EMIT,
    ST_FAIL
  } state_t;

  typedef enum logic [1:0] {
    OP_DIV,
    OP_SQRT
  } op_t;

  typedef struct packed {
    logic              acc_clr;
    logic              acc_en;
    logic              mul_en;
    logic              lat_a;
    logic              lat_b;
    logic              lat_d;
    logic              lat_arr;
    logic              start;
    op_t               op;
    logic [ADDR_W-1:0] fraddr_a;
    logic [ADDR_W-1:0] fraddr_b;
    logic [ADDR_W-1:0] faddr_w;
    logic              fwe;
  } dp_cmd_t;

  typedef struct packed {
    logic              busy;
    logic              d_bad;
    logic              arr_bad;
    logic              val_bad;
    logic              root_zero;
  } dp_sts_t;

endpackage

@@ rtl/cholesky_decomposition.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cholesky_decomposition
// Streams in an n x n Q16.16 matrix, factors it and streams out L row-major.
// ----------------------------------------------------------------------------
// Loading accepts one element per cycle while in_ready is high. After the last
// element, the factor is computed entry by entry through one multiplier and a
// shared bit-serial divide/root unit. An 8x8 matrix then gives 64 results, which
// leave one at a time, each read through ST_EMIT_RD, ST_EMIT_W and ST_EMIT.
// A failure gives a single result with status set and last set.
module cholesky_decomposition
  import chol_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [3:0]               cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [DATA_W-1:0] in_a_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] out_l_value,
  output logic                     out_status,
  output logic                     out_last
);
  logic [3:0] size_r;
  logic a_we;
  logic [ADDR_W-1:0] a_waddr, a_raddr;
  logic [DATA_W-1:0] a_rdata, l_rdata;
  dp_cmd_t cmd;
  dp_sts_t sts;

  always_ff @(posedge clk) begin
    if (!rst_n) size_r <= 4'd8;
    else if (cfg_we) size_r <= cfg_data;
  end

  chol_ram #(.WIDTH(DATA_W), .DEPTH(64)) u_astore (
    .clk(clk), .we(a_we), .waddr(a_waddr), .wdata(in_a_value),
    .raddr(a_raddr), .rdata(a_rdata));

  chol_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .a_rdata(a_rdata),
    .l_rdata(l_rdata), .sts(sts));

  chol_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .size(size_r), .in_valid(in_valid),
    .in_ready(in_ready), .a_we(a_we), .a_waddr(a_waddr), .a_raddr(a_raddr),
    .cmd(cmd), .sts(sts), .l_rdata(l_rdata), .out_valid(out_valid),
    .out_ready(out_ready), .out_l_value(out_l_value), .out_status(out_status),
    .out_last(out_last));

  a_fail_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_last)
    else $error("failure beat without last");
  a_no_in_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input taken while result pending");
endmodule

@@ rtl/chol_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chol_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module chol_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/chol_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chol_datapath
// Factor store, multiplier, accumulator and a shared restoring divide/root unit.
// ----------------------------------------------------------------------------
module chol_datapath
  import chol_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  dp_cmd_t           cmd,
  input  logic [DATA_W-1:0] a_rdata,
  output logic [DATA_W-1:0] l_rdata,
  output dp_sts_t           sts
);
  localparam int UW = 128;
  localparam int SQ_STEPS = 32;
  localparam int DV_STEPS = 64;
  localparam logic signed [ACC_W-1:0] SMAX = 64'sd2147483647;
  localparam logic signed [ACC_W-1:0] SMIN = -64'sd2147483648;

  logic [DATA_W-1:0] rd_b;
  logic signed [DATA_W-1:0] opa_r, opb_r, d_r, arr_r;
  logic signed [ACC_W-1:0] prod_r, acc_r, diff;
  logic [DATA_W-1:0] res_r;

  chol_ram #(.WIDTH(DATA_W), .DEPTH(64)) u_fa (
    .clk(clk), .we(cmd.fwe), .waddr(cmd.faddr_w), .wdata(res_r),
    .raddr(cmd.fraddr_a), .rdata(l_rdata));
  chol_ram #(.WIDTH(DATA_W), .DEPTH(64)) u_fb (
    .clk(clk), .we(cmd.fwe), .waddr(cmd.faddr_w), .wdata(res_r),
    .raddr(cmd.fraddr_b), .rdata(rd_b));

  function automatic logic signed [ACC_W-1:0] sat_trunc(input logic signed [ACC_W-1:0] p);
    logic signed [ACC_W-1:0] q;
    begin
      q = p >>> FRAC_BITS;
      if (p < 0 && (p & ((64'sd1 <<< FRAC_BITS) - 1)) != 0) q = q + 1;
      if (q > SMAX) q = SMAX;
      if (q < SMIN) q = SMIN;
      return q;
    end
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.lat_a) opa_r <= l_rdata;
    if (cmd.lat_b) opb_r <= rd_b;
    if (cmd.lat_d) d_r <= l_rdata;
    if (cmd.lat_arr) arr_r <= a_rdata;
    if (cmd.mul_en) prod_r <= ACC_W'(opa_r) * ACC_W'(opb_r);
    if (cmd.acc_clr) acc_r <= '0;
    else if (cmd.acc_en) acc_r <= acc_r + sat_trunc(prod_r);
  end

  assign diff = ACC_W'(arr_r) - acc_r;

  // iterative unit: restoring divide (1 bit/cycle) or digit root (1 bit/cycle)
  logic [UW-1:0] rem_r, num_r, res_w_r;
  logic [6:0]    cnt_r;
  logic          busy_r, neg_r;
  op_t           op_r;
  logic [UW-1:0] trial, den;
  logic [UW-1:0] shin;

  assign den = UW'(d_r[DATA_W-2:0]) | (UW'(d_r[DATA_W-1]) << (DATA_W-1));
  always_comb begin
    shin  = '0;
    trial = '0;
    if (op_r == OP_DIV) begin
      shin  = {rem_r[UW-2:0], num_r[DV_STEPS*2-1]};
      trial = den;
    end else begin
      shin  = {rem_r[UW-3:0], num_r[UW-1:UW-2]};
      trial = {res_w_r[UW-3:0], 2'b01};
    end
  end

  logic [UW-1:0] absd;
  assign absd = diff[ACC_W-1] ? UW'(-diff) : UW'(diff);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (cmd.start) begin
      busy_r  <= 1'b1;
      op_r    <= cmd.op;
      rem_r   <= '0;
      res_w_r <= '0;
      if (cmd.op == OP_DIV) begin
        num_r <= (absd << FRAC_BITS) << (UW - DV_STEPS*2 + DV_STEPS);
        cnt_r <= 7'(DV_STEPS);
        neg_r <= diff[ACC_W-1];
      end else begin
        num_r <= (UW'(diff) << FRAC_BITS) << (UW - 2*SQ_STEPS*2);
        cnt_r <= 7'(SQ_STEPS*2);
        neg_r <= 1'b0;
      end
    end else if (busy_r) begin
      num_r <= (op_r == OP_DIV) ? (num_r << 1) : (num_r << 2);
      if (shin >= trial) begin
        rem_r   <= shin - trial;
        res_w_r <= {res_w_r[UW-2:0], 1'b1};
      end else begin
        rem_r   <= shin;
        res_w_r <= {res_w_r[UW-2:0], 1'b0};
      end
      cnt_r <= cnt_r - 7'd1;
      if (cnt_r == 7'd1) busy_r <= 1'b0;
    end
  end

  // saturate the finished quotient or root
  logic signed [UW-1:0] sq;
  always_comb begin
    sq = neg_r ? -$signed(res_w_r) : $signed(res_w_r);
    if (sq > $signed(UW'(SMAX))) res_r = DATA_W'(SMAX);
    else if (sq < $signed({{(UW-ACC_W){1'b1}}, SMIN})) res_r = DATA_W'(SMIN);
    else res_r = sq[DATA_W-1:0];
  end

  assign sts.busy      = busy_r | cmd.start;
  assign sts.d_bad     = d_r[DATA_W-1] | (d_r == '0);
  assign sts.arr_bad   = arr_r[DATA_W-1] | (arr_r == '0);
  assign sts.val_bad   = diff[ACC_W-1] | (diff == '0);
  assign sts.root_zero = (res_w_r == '0);
endmodule

@@ rtl/chol_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chol_ctrl
// Sequencer: loading, row/column/dot loops, and row-major emit of L or of a failure beat.
// ----------------------------------------------------------------------------
module chol_ctrl
  import chol_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic [3:0]        size,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              a_we,
  output logic [ADDR_W-1:0] a_waddr,
  output logic [ADDR_W-1:0] a_raddr,
  output dp_cmd_t           cmd,
  input  dp_sts_t           sts,
  input  logic [DATA_W-1:0] l_rdata,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] out_l_value,
  output logic              out_status,
  output logic              out_last
);
  state_t st_r, st_nxt;
  logic [6:0] cnt_r;
  logic [IDX_W-1:0] lrow_r, lcol_r, r_r, c_r, j_r, er_r, ec_r;
  logic [3:0] n;
  logic [6:0] total;
  logic       ov_r, ostat_r, olast_r;
  logic [DATA_W-1:0] oval_r;
  logic       diag;

  assign n     = (size == 4'd0) ? 4'd1 : (size > 4'd8) ? 4'd8 : size;
  assign total = 7'(n) * 7'(n);
  assign diag  = (c_r == r_r);

  wire [3:0] nm1 = n - 4'd1;
  wire in_acc = in_valid & in_ready;
  wire out_free = !ov_r | out_ready;

  assign in_ready = (st_r == ST_LOAD) && !ov_r;
  assign a_we     = in_acc && (4'(lrow_r) < n) && (lcol_r <= lrow_r) && (cnt_r < 7'd64);
  assign a_waddr  = {lrow_r, lcol_r};
  assign a_raddr  = {r_r, c_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_LOAD;
      cnt_r <= '0; lrow_r <= '0; lcol_r <= '0;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (ov_r && out_ready) ov_r <= 1'b0;
      if (in_acc) begin
        if (cnt_r + 7'd1 >= total) begin
          cnt_r <= '0; lrow_r <= '0; lcol_r <= '0; r_r <= '0;
        end else begin
          cnt_r <= cnt_r + 7'd1;
          if (4'(lcol_r) == nm1) begin lcol_r <= '0; lrow_r <= lrow_r + 1'b1; end
          else lcol_r <= lcol_r + 1'b1;
        end
      end
      unique case (st_r)
        ST_ROW:     begin c_r <= '0; end
        ST_COL:     j_r <= '0;
        ST_DOT_ACC: j_r <= j_r + 1'b1;
        ST_WR: begin
          if (diag) begin r_r <= r_r + 1'b1; c_r <= '0; er_r <= '0; ec_r <= '0; end
          else c_r <= c_r + 1'b1;
        end
        ST_EMIT: if (out_free) begin
          ov_r <= 1'b1; ostat_r <= 1'b0;
          oval_r  <= (ec_r <= er_r) ? l_rdata : '0;
          olast_r <= (4'(er_r) == nm1) && (4'(ec_r) == nm1);
          if (4'(ec_r) == nm1) begin ec_r <= '0; er_r <= er_r + 1'b1; end
          else ec_r <= ec_r + 1'b1;
        end
        ST_FAIL: if (out_free) begin
          ov_r <= 1'b1; ostat_r <= 1'b1; olast_r <= 1'b1; oval_r <= '0;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_LOAD:    if (in_acc && cnt_r + 7'd1 >= total) st_nxt = ST_ROW;
      ST_ROW:     st_nxt = ST_COL;
      ST_COL:     st_nxt = ST_RD_D;
      ST_RD_D:    st_nxt = ST_WT_D;
      ST_WT_D:    st_nxt = (j_r < (diag ? r_r : c_r)) ? ST_DOT_RD : ST_RD_A;
      ST_DOT_RD:  st_nxt = ST_DOT_W1;
      ST_DOT_W1:  st_nxt = ST_DOT_W2;
      ST_DOT_W2:  st_nxt = ST_DOT_MUL;
      ST_DOT_MUL: st_nxt = ST_DOT_ACC;
      ST_DOT_ACC: st_nxt = (j_r + 1'b1 < (diag ? r_r : c_r)) ? ST_DOT_RD : ST_RD_A;
      ST_RD_A:    st_nxt = ST_WT_A;
      ST_WT_A:    st_nxt = ST_CHK;
      ST_CHK: begin
        if (diag) st_nxt = (sts.arr_bad || sts.val_bad) ? ST_FAIL : ST_SQRT;
        else      st_nxt = sts.d_bad ? ST_FAIL : ST_DIV;
      end
      ST_DIV:     if (!sts.busy) st_nxt = ST_WR;
      ST_SQRT:    if (!sts.busy) st_nxt = sts.root_zero ? ST_FAIL : ST_WR;
      ST_WR:      st_nxt = (diag && 4'(r_r) == nm1) ? ST_EMIT_RD : (diag ? ST_ROW : ST_COL);
      ST_EMIT_RD: st_nxt = ST_EMIT_W;
      ST_EMIT_W:  st_nxt = ST_EMIT;
      ST_EMIT: begin
        if (out_free) st_nxt = ((4'(er_r) == nm1) && (4'(ec_r) == nm1)) ? ST_LOAD : ST_EMIT_RD;
      end
      ST_FAIL:    if (out_free) st_nxt = ST_LOAD;
      default:    st_nxt = ST_LOAD;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.op       = diag ? OP_SQRT : OP_DIV;
    cmd.fraddr_a = {c_r, c_r};
    cmd.fraddr_b = {r_r, j_r};
    cmd.faddr_w  = {r_r, c_r};
    cmd.start    = 1'b0;
    unique case (st_r)
      ST_COL:     cmd.acc_clr = 1'b1;
      ST_WT_D:    cmd.lat_d = 1'b1;
      ST_DOT_RD:  cmd.fraddr_a = diag ? {r_r, j_r} : {c_r, j_r};
      ST_DOT_W1:  cmd.fraddr_a = diag ? {r_r, j_r} : {c_r, j_r};
      ST_DOT_W2:  begin cmd.lat_a = 1'b1; cmd.lat_b = 1'b1; end
      ST_DOT_MUL: cmd.mul_en = 1'b1;
      ST_DOT_ACC: cmd.acc_en = 1'b1;
      ST_WT_A:    cmd.lat_arr = 1'b1;
      ST_CHK:     cmd.start = 1'b1;
      ST_WR:      cmd.fwe = 1'b1;
      ST_EMIT_RD, ST_EMIT_W, ST_EMIT: cmd.fraddr_a = {er_r, ec_r};
      default: ;
    endcase
    if (st_r == ST_CHK) cmd.start = (st_nxt == ST_DIV || st_nxt == ST_SQRT);
  end

  assign out_valid   = ov_r;
  assign out_l_value = oval_r;
  assign out_status  = ostat_r;
  assign out_last    = olast_r;
endmodule

@@ verif/cholesky_decomposition_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cholesky_decomposition_tb
// Streams Q16.16 matrices of several orders (symmetric ones and random noise) into
// the factor block, predicts L (or the single failure beat) and checks every output beat.
// ----------------------------------------------------------------------------
module cholesky_decomposition_tb;

  localparam int MAXN = 8;
  localparam int FB = 16;
  localparam int WD_LIMIT = 40000;

  typedef struct packed {
    logic signed [31:0] l_value;
    logic               status;
    logic               last;
  } l_beat_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [3:0] cfg_data;
  logic in_valid;
  logic in_ready;
  logic signed [31:0] in_a_value;
  logic out_valid;
  logic out_ready;
  logic signed [31:0] out_l_value;
  logic out_status;
  logic out_last;

  cholesky_decomposition dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_a_value(in_a_value),
    .out_valid(out_valid), .out_ready(out_ready), .out_l_value(out_l_value),
    .out_status(out_status), .out_last(out_last)
  );

  // predictor state
  logic signed [31:0] a_lower [MAXN*MAXN];
  logic signed [31:0] l_fact [MAXN*MAXN];
  int unsigned elem_count;
  logic [3:0] order_reg;
  l_beat_t l_expected [$];

  int errors;
  bit in_gaps;
  bit out_gaps;
  int idle_cycles;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic logic signed [31:0] sat32(logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [63:0] q_product(logic signed [31:0] a,
                                                    logic signed [31:0] b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b);
    return 64'(sat32(p / 64'sd65536));
  endfunction

  function automatic logic [63:0] floor_root(logic [63:0] x);
    logic [63:0] rem, res, bitv;
    rem = x;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (rem >= res + bitv) begin
        rem -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic int unsigned active_order();
    if (order_reg == 0) return 1;
    if (order_reg > MAXN) return MAXN;
    return order_reg;
  endfunction

  function automatic bit factor_lower(int unsigned n);
    logic signed [63:0] sum, diff, q, val;
    logic signed [31:0] d, arr, lv;
    logic [63:0] root;
    for (int i = 0; i < MAXN*MAXN; i++) l_fact[i] = 0;
    for (int r = 0; r < n; r++) begin
      for (int c = 0; c < r; c++) begin
        sum = 0;
        d = l_fact[c*MAXN+c];
        for (int j = 0; j < c; j++) sum += q_product(l_fact[c*MAXN+j], l_fact[r*MAXN+j]);
        diff = 64'(a_lower[r*MAXN+c]) - sum;
        if (d <= 0) return 0;
        q = (diff * 64'sd65536) / 64'(d);
        l_fact[r*MAXN+c] = sat32(q);
      end
      arr = a_lower[r*MAXN+r];
      if (arr <= 0) return 0;
      sum = 0;
      for (int j = 0; j < r; j++) begin
        lv = l_fact[r*MAXN+j];
        sum += q_product(lv, lv);
      end
      val = 64'(arr) - sum;
      if (val <= 0) return 0;
      root = floor_root(64'(val) << FB);
      if (root == 0) return 0;
      l_fact[r*MAXN+r] = sat32($signed(root));
    end
    return 1;
  endfunction

  function automatic void predict_element(logic signed [31:0] a);
    int unsigned n, total, row, col;
    l_beat_t b;
    n = active_order();
    total = n * n;
    row = elem_count / n;
    col = elem_count % n;
    if (row < n && col <= row) a_lower[row*MAXN+col] = a;
    elem_count = (elem_count + 1) & 7'h7f;
    if (elem_count < total) return;
    elem_count = 0;
    if (!factor_lower(n)) begin
      b.l_value = 0; b.status = 1; b.last = 1;
      l_expected.push_back(b);
      return;
    end
    for (int k = 0; k < total; k++) begin
      b.l_value = (k % n <= k / n) ? l_fact[(k/n)*MAXN + k%n] : 32'sd0;
      b.status = 0;
      b.last = (k + 1 == total);
      l_expected.push_back(b);
    end
  endfunction

  // send one element of A; hold valid until the beat is taken
  task automatic send_element(logic signed [31:0] a);
    int gap;
    if (in_gaps && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 19);
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_a_value <= a;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_element(a);
  endtask

  task automatic drain_and_settle();
    in_valid <= 0;
    while (l_expected.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_order(int unsigned n);
    cfg_we <= 1;
    cfg_data <= n[3:0];
    @(posedge clk);
    cfg_we <= 0;
    order_reg = n[3:0];
  endtask

  // symmetric diagonally dominant matrix with small random content
  task automatic send_spd(int unsigned n, int unsigned mag);
    logic signed [31:0] m [MAXN][MAXN];
    int signed v;
    for (int r = 0; r < n; r++)
      for (int c = 0; c <= r; c++) begin
        v = $urandom_range(0, 2*mag) - mag;
        m[r][c] = v;
        m[c][r] = v;
      end
    for (int r = 0; r < n; r++) m[r][r] = (n + 1) * mag + $urandom_range(1, 65536);
    for (int r = 0; r < n; r++)
      for (int c = 0; c < n; c++) send_element(m[r][c]);
  endtask

  task automatic send_noise(int unsigned n);
    for (int i = 0; i < n*n; i++) send_element($urandom());
  endtask

  task automatic test_extremes();
    set_order(1);
    send_element(32'sh7fffffff);
    send_element(32'sh80000000);
    send_element(32'sd0);
    send_element(32'sd1);
    send_element(32'sh00010000);
    drain_and_settle();
  endtask

  task automatic test_failures();
    set_order(2);
    // diagonal entry not positive
    send_element(-32'sd65536); send_element(0); send_element(0); send_element(32'sh10000);
    // remainder after the sum not positive
    send_element(32'sh10000); send_element(32'sh20000);
    send_element(32'sh20000); send_element(32'sh40000);
    // good 2x2
    send_element(32'sh40000); send_element(32'sh20000);
    send_element(32'sh20000); send_element(32'sh50000);
    drain_and_settle();
    // out of range sizes
    set_order(0);
    send_element(32'sh90000);
    drain_and_settle();
    set_order(15);
    send_spd(8, 65536);
    drain_and_settle();
  endtask

  task automatic test_random();
    int unsigned n, sent;
    sent = 0;
    while (sent < 390) begin
      n = $urandom_range(1, 8);
      if (sent > 320) begin
        in_gaps = 0;
        out_gaps = 0;
      end
      set_order(n);
      if ($urandom_range(0, 4) == 0) send_noise(n);
      else send_spd(n, $urandom_range(1, 1 << $urandom_range(1, 24)));
      sent += n * n;
      drain_and_settle();
    end
  endtask

  // result checker
  always @(posedge clk) begin
    l_beat_t e;
    if (rst_n && out_valid && out_ready) begin
      if (l_expected.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual l=%h status=%b last=%b",
                 $time, out_l_value, out_status, out_last);
        errors++;
      end else begin
        e = l_expected.pop_front();
        if (e.l_value !== out_l_value) begin
          $display("%0t: l_value expected %h actual %h", $time, e.l_value, out_l_value);
          errors++;
        end
        if (e.status !== out_status) begin
          $display("%0t: status expected %b actual %b", $time, e.status, out_status);
          errors++;
        end
        if (e.last !== out_last) begin
          $display("%0t: last expected %b actual %b", $time, e.last, out_last);
          errors++;
        end
      end
    end
  end

  // receiver stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 0;
    end else if (idle_cycles > 0) begin
      idle_cycles <= idle_cycles - 1;
      out_ready <= (idle_cycles == 1);
    end else if (out_gaps && $urandom_range(0, 7) == 0) begin
      idle_cycles <= $urandom_range(1, 19);
      out_ready <= 0;
    end else begin
      out_ready <= 1;
    end
  end

  // watchdog on cycles without any accepted beat
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
      if (quiet >= WD_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    errors = 0;
    idle_cycles = 0;
    in_gaps = 1;
    out_gaps = 1;
    rst_n = 0;
    cfg_we = 0;
    cfg_data = 0;
    in_valid = 0;
    in_a_value = 0;
    elem_count = 0;
    order_reg = 8;
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    test_extremes();
    test_failures();
    test_random();
    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
